### sv/sfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants for the stuffed frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam logic [7:0] DELIM_BYTE    = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] FLIP_MASK     = 8'h20;
    localparam logic [2:0] PAYLOAD_BYTES = 3'd7;
    localparam int         CAPTURE_W     = 56;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_ESCAPE   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] transaction_id;
        logic [7:0]  operation;
        logic [15:0] address;
        logic [15:0] value;
        logic        is_notification;
    } result_t;

endpackage
`default_nettype wire

### sv/stuffed_frame_receiver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_core
// byte-stuffed frame deframer with on-the-fly unstuffing
// input channel: one raw serial byte per request on rx_byte, taken at a
//   rising edge with in_valid high and in_stall low
// output channel: one frame report per request (status plus the decoded
//   transaction id, operation, address and value), taken at a rising edge
//   with out_valid high and out_stall low
// a 0x7e byte opens a frame when idle and closes it when inside one; a
//   closing byte or a raw overflow produces a report, every other byte
//   produces none
// report path: input register, decode, then the result register or skid entry
// throughput: one byte per cycle while in_stall is low
// stalls: a result register plus one skid entry hold reports; in_stall
//   rises only while the skid entry is full and a byte waits in the input
//   register
// reset: frame state, counters and all valid flags clear at once; the
//   payload capture register holds no reset value and is only read once
//   seven bytes have been written into it
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_core #(
    parameter int MAX_RAW_LEN = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // frame report output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [15:0]      transaction_id,
    output logic [7:0]       operation,
    output logic [15:0]      address,
    output logic [15:0]      value,
    output logic             is_notification
);

    // raw counter must hold MAX_RAW_LEN itself
    localparam int RAW_W = $clog2(MAX_RAW_LEN + 1);
    localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(MAX_RAW_LEN);

    // input register
    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_reg;

    // frame state
    logic             inside_frame_reg, inside_frame_next;
    logic             escape_pending_reg, escape_pending_next;
    logic [RAW_W-1:0] raw_count_reg, raw_count_next;
    logic [2:0]       payload_count_reg, payload_count_next;
    logic [sfr_pkg::CAPTURE_W-1:0] capture_reg, capture_next;

    // result register and skid entry
    logic             res_valid_reg, res_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    sfr_pkg::result_t res_reg, res_next;
    sfr_pkg::result_t skid_reg, skid_next;

    logic             in_fire;
    logic             proc_fire;
    logic             out_fire;
    logic             push;
    logic             take;
    logic [7:0]       take_byte;
    sfr_pkg::result_t push_res;

    assign in_stall  = byte_valid_reg && skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    // the held byte is decoded whenever a free slot is guaranteed for its report
    assign proc_fire = byte_valid_reg && !skid_valid_reg;
    assign out_fire  = res_valid_reg && !out_stall;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (in_fire)
        begin
            byte_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            byte_valid_next = 1'b0;
        end
    end

    // per-byte decode
    always_comb
    begin
        inside_frame_next   = inside_frame_reg;
        escape_pending_next = escape_pending_reg;
        raw_count_next      = raw_count_reg;
        payload_count_next  = payload_count_reg;
        capture_next        = capture_reg;
        push                = 1'b0;
        take                = 1'b0;
        take_byte           = byte_reg;
        push_res            = '0;

        if (proc_fire)
        begin
            if (byte_reg == sfr_pkg::DELIM_BYTE)
            begin
                escape_pending_next = 1'b0;
                raw_count_next      = '0;
                payload_count_next  = '0;
                if (!inside_frame_reg)
                begin
                    inside_frame_next = 1'b1;
                end
                else
                begin
                    // closing delimiter: escape check wins over length check
                    inside_frame_next = 1'b0;
                    push              = 1'b1;
                    if (escape_pending_reg)
                    begin
                        push_res.status = sfr_pkg::ST_ESCAPE;
                    end
                    else if (payload_count_reg < sfr_pkg::PAYLOAD_BYTES)
                    begin
                        push_res.status = sfr_pkg::ST_SHORT;
                    end
                    else
                    begin
                        push_res.status          = sfr_pkg::ST_OK;
                        push_res.transaction_id  = capture_reg[55:40];
                        push_res.operation       = capture_reg[39:32];
                        push_res.address         = capture_reg[31:16];
                        push_res.value           = capture_reg[15:0];
                        push_res.is_notification = (capture_reg[55:40] == 16'h0000);
                    end
                end
            end
            else if (inside_frame_reg)
            begin
                if (raw_count_reg >= RAW_LIMIT)
                begin
                    // raw overflow: drop the byte and abort the frame
                    inside_frame_next   = 1'b0;
                    escape_pending_next = 1'b0;
                    raw_count_next      = '0;
                    payload_count_next  = '0;
                    push                = 1'b1;
                    push_res.status     = sfr_pkg::ST_OVERFLOW;
                end
                else
                begin
                    raw_count_next = raw_count_reg + RAW_W'(1);
                    if (escape_pending_reg)
                    begin
                        escape_pending_next = 1'b0;
                        take                = 1'b1;
                        take_byte           = byte_reg ^ sfr_pkg::FLIP_MASK;
                    end
                    else if (byte_reg == sfr_pkg::ESC_BYTE)
                    begin
                        escape_pending_next = 1'b1;
                    end
                    else
                    begin
                        take = 1'b1;
                    end
                end
            end
        end

        // bytes past the seventh are counted but not kept
        if (take && (payload_count_reg < sfr_pkg::PAYLOAD_BYTES))
        begin
            capture_next       = {capture_reg[sfr_pkg::CAPTURE_W-9:0], take_byte};
            payload_count_next = payload_count_reg + 3'd1;
        end
    end

    // result register with one skid entry
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        skid_valid_next = skid_valid_reg;
        res_next        = res_reg;
        skid_next       = skid_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                res_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                res_next       = push_res;
                res_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!res_valid_reg)
            begin
                res_next       = push_res;
                res_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg     <= 1'b0;
            inside_frame_reg   <= 1'b0;
            escape_pending_reg <= 1'b0;
            raw_count_reg      <= '0;
            payload_count_reg  <= '0;
            res_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            byte_valid_reg     <= byte_valid_next;
            inside_frame_reg   <= inside_frame_next;
            escape_pending_reg <= escape_pending_next;
            raw_count_reg      <= raw_count_next;
            payload_count_reg  <= payload_count_next;
            res_valid_reg      <= res_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= rx_byte;
        end
        capture_reg <= capture_next;
        res_reg     <= res_next;
        skid_reg    <= skid_next;
    end

    assign out_valid       = res_valid_reg;
    assign status          = res_reg.status;
    assign transaction_id  = res_reg.transaction_id;
    assign operation       = res_reg.operation;
    assign address         = res_reg.address;
    assign value           = res_reg.value;
    assign is_notification = res_reg.is_notification;

    // skid entry only fills behind a waiting result
    a_skid_behind_res: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid entry valid without result register");

    // raw counter never passes the limit
    a_raw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        raw_count_reg <= RAW_LIMIT)
        else $error("raw count beyond limit");

    // idle state carries no leftover frame context
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_frame_reg |-> (raw_count_reg == '0) && !escape_pending_reg
                              && (payload_count_reg == 3'd0))
        else $error("frame context left while idle");

    // error reports carry zero fields
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status != sfr_pkg::ST_OK))
            |-> (res_reg.transaction_id == 16'h0000) && (res_reg.operation == 8'h00)
                && (res_reg.address == 16'h0000) && (res_reg.value == 16'h0000)
                && !res_reg.is_notification)
        else $error("error report with non-zero fields");

    // a byte never waits in the input register while reports can drain
    a_no_stuck_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid_reg && !skid_valid_reg) |=> (!byte_valid_reg || $past(in_fire)))
        else $error("input byte not decoded");

endmodule
`default_nettype wire

### sim/sfr_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_frame_checker
// watches both channels of the stuffed frame receiver and checks its reports
//
// every byte request taken on the input channel goes through a local
// deframer that keeps its own frame state, and any report that byte causes
// is queued. every report request taken on the output channel is compared
// field by field with the oldest queued report.
// ----------------------------------------------------------------------------
module sfr_frame_checker #(
    parameter int MAX_RAW_LEN = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_stall,
    input  wire logic [7:0]   rx_byte,
    input  wire logic         out_valid,
    input  wire logic         out_stall,
    input  wire logic [1:0]   status,
    input  wire logic [15:0]  transaction_id,
    input  wire logic [7:0]   operation,
    input  wire logic [15:0]  address,
    input  wire logic [15:0]  value,
    input  wire logic         is_notification,
    output int                fail_count,
    output int                pending,
    output logic [3:0][15:0]  status_tally
);

    // local deframer state
    logic                          framing;
    logic                          esc_armed;
    int                            raw_seen;
    logic [2:0]                    payload_seen;
    logic [sfr_pkg::CAPTURE_W-1:0] capture;

    sfr_pkg::result_t expected_reports[$];

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endtask

    task automatic keep_payload(input logic [7:0] b);
        if (payload_seen < sfr_pkg::PAYLOAD_BYTES)
        begin
            capture      = {capture[sfr_pkg::CAPTURE_W-9:0], b};
            payload_seen = payload_seen + 3'd1;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        sfr_pkg::result_t rpt;
        rpt = '0;
        if (b == sfr_pkg::DELIM_BYTE)
        begin
            if (!framing)
            begin
                framing      = 1'b1;
                esc_armed    = 1'b0;
                raw_seen     = 0;
                payload_seen = '0;
            end
            else
            begin
                framing = 1'b0;
                // a pending escape outranks the length check
                if (esc_armed)
                begin
                    rpt.status = sfr_pkg::ST_ESCAPE;
                end
                else if (payload_seen < sfr_pkg::PAYLOAD_BYTES)
                begin
                    rpt.status = sfr_pkg::ST_SHORT;
                end
                else
                begin
                    rpt.status          = sfr_pkg::ST_OK;
                    rpt.transaction_id  = capture[55:40];
                    rpt.operation       = capture[39:32];
                    rpt.address         = capture[31:16];
                    rpt.value           = capture[15:0];
                    rpt.is_notification = (capture[55:40] == 16'h0000);
                end
                expected_reports.push_back(rpt);
                esc_armed    = 1'b0;
                raw_seen     = 0;
                payload_seen = '0;
            end
        end
        else if (framing)
        begin
            if (raw_seen >= MAX_RAW_LEN)
            begin
                // frame full: the byte is dropped and the frame aborted
                framing      = 1'b0;
                esc_armed    = 1'b0;
                raw_seen     = 0;
                payload_seen = '0;
                rpt.status   = sfr_pkg::ST_OVERFLOW;
                expected_reports.push_back(rpt);
            end
            else
            begin
                raw_seen++;
                if (esc_armed)
                begin
                    esc_armed = 1'b0;
                    keep_payload(b ^ sfr_pkg::FLIP_MASK);
                end
                else if (b == sfr_pkg::ESC_BYTE)
                begin
                    esc_armed = 1'b1;
                end
                else
                begin
                    keep_payload(b);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sfr_pkg::result_t want;
        if (!rst_n)
        begin
            framing      = 1'b0;
            esc_armed    = 1'b0;
            raw_seen     = 0;
            payload_seen = '0;
            capture      = '0;
            fail_count   = 0;
            status_tally = '0;
            expected_reports.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected report: status %0d with nothing outstanding", status);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("transaction_id", want.transaction_id, transaction_id);
                    check_field("operation", 16'(want.operation), 16'(operation));
                    check_field("address", want.address, address);
                    check_field("value", want.value, value);
                    check_field("is_notification", 16'(want.is_notification),
                                16'(is_notification));
                    status_tally[want.status] = status_tally[want.status] + 16'd1;
                end
            end
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
        end
        pending = expected_reports.size();
    end

endmodule
`default_nettype wire

### sim/tb_stuffed_frame_receiver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_stuffed_frame_receiver_core
// stimulus and verdict for the stuffed frame receiver
//
// a short directed stream covers the field extremes, escaped delimiter and
// escape bytes, empty and dangling-escape frames and bytes between frames.
// the random part is mostly well-formed command frames with random content
// and random stuffing, mixed with short frames, dangling escapes, line noise
// and a few frames around the raw length limit. both channels idle and stall
// at random; a separate checker predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_receiver_core;

    localparam int RAW_LIMIT      = 256;
    localparam int ITEM_TARGET    = 1450;
    localparam int DRAIN_CYCLES   = 8;
    // longest quiet spell is a sender gap plus a receiver stall
    localparam int WATCHDOG_LIMIT = 500;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] transaction_id;
    logic [7:0]  operation;
    logic [15:0] address;
    logic [15:0] value;
    logic        is_notification;

    int               fail_count;
    int               pending;
    logic [3:0][15:0] status_tally;

    // bookkeeping for the stimulus
    int bytes_sent  = 0;
    int noise_bytes = 0;
    int idle_cycles = 0;
    // while set, neither side inserts gaps or stalls
    bit calm        = 1'b0;

    stuffed_frame_receiver_core #(
        .MAX_RAW_LEN (RAW_LIMIT)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .transaction_id  (transaction_id),
        .operation       (operation),
        .address         (address),
        .value           (value),
        .is_notification (is_notification)
    );

    sfr_frame_checker #(
        .MAX_RAW_LEN (RAW_LIMIT)
    ) u_frame_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .transaction_id  (transaction_id),
        .operation       (operation),
        .address         (address),
        .value           (value),
        .is_notification (is_notification),
        .fail_count      (fail_count),
        .pending         (pending),
        .status_tally    (status_tally)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: any taken request on either side counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request taken for %0d cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // report side: out_stall is raised at random before each report request, never while calm
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 3);
            if (hold != 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // one byte request; the gap in front of it is drawn per byte, and valid
    // is only lowered at a falling edge where it is not raised again
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // stuff one payload byte: delimiter and escape must be escaped, other
    // bytes sometimes are (never 0x5e, whose escaped form is the delimiter)
    task automatic send_payload_byte(input logic [7:0] b);
        if (b == sfr_pkg::DELIM_BYTE || b == sfr_pkg::ESC_BYTE ||
            (b != (sfr_pkg::DELIM_BYTE ^ sfr_pkg::FLIP_MASK) &&
             $urandom_range(0, 7) == 0))
        begin
            send_byte(sfr_pkg::ESC_BYTE);
            send_byte(b ^ sfr_pkg::FLIP_MASK);
        end
        else
        begin
            send_byte(b);
        end
    endtask

    // random payload byte, biased towards extremes and bytes needing escape
    function automatic logic [7:0] pick_data_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return sfr_pkg::DELIM_BYTE;
            3:       return sfr_pkg::ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // complete frame of n unstuffed bytes; seven or more give a command
    task automatic send_command_frame(input int n);
        logic [7:0] b;
        bit         notify;
        notify = ($urandom_range(0, 3) == 0);
        send_byte(sfr_pkg::DELIM_BYTE);
        for (int k = 0; k < n; k++)
        begin
            if (k < 2 && notify)
                b = 8'h00;
            else if (k == 2 && $urandom_range(0, 3) != 0)
                b = 8'($urandom_range(0, 1));
            else
                b = pick_data_byte();
            send_payload_byte(b);
        end
        send_byte(sfr_pkg::DELIM_BYTE);
    endtask

    // frame closed straight after an escape byte
    task automatic send_dangling_frame();
        int n;
        n = $urandom_range(0, 8);
        send_byte(sfr_pkg::DELIM_BYTE);
        repeat (n) send_payload_byte(pick_data_byte());
        send_byte(sfr_pkg::ESC_BYTE);
        send_byte(sfr_pkg::DELIM_BYTE);
    endtask

    // bytes between frames, none of them a delimiter, so all are ignored
    task automatic send_line_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 4))
        begin
            b = 8'($urandom_range(0, 255));
            if (b == sfr_pkg::DELIM_BYTE)
                b = 8'h00;
            send_byte(b);
            noise_bytes++;
        end
    endtask

    // frame of exactly raw_len raw bytes around the limit; a stray escape
    // may land anywhere, the boundary included. past the limit the frame
    // aborts by itself, so only frames within the limit get a closing byte
    task automatic send_long_frame(input int raw_len);
        logic [7:0] b;
        send_byte(sfr_pkg::DELIM_BYTE);
        repeat (raw_len)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == sfr_pkg::DELIM_BYTE)
                b = sfr_pkg::ESC_BYTE;
            send_byte(b);
        end
        if (raw_len <= RAW_LIMIT)
            send_byte(sfr_pkg::DELIM_BYTE);
    endtask

    // sender pause until every outstanding report has been taken
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] directed_bytes[];
        int         frame_no;
        int         long_no;
        int         kind;

        in_valid = 1'b0;
        rx_byte  = 8'h00;
        rst_n    = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        directed_bytes = '{
            // ignored while idle, escape byte included
            8'h00, 8'hFF, sfr_pkg::ESC_BYTE,
            // empty frame
            sfr_pkg::DELIM_BYTE, sfr_pkg::DELIM_BYTE,
            // notification, operation read, address and value all ones
            sfr_pkg::DELIM_BYTE, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            sfr_pkg::DELIM_BYTE,
            // escaped delimiter and escaped escape in the transaction id
            sfr_pkg::DELIM_BYTE, sfr_pkg::ESC_BYTE, 8'h5E, sfr_pkg::ESC_BYTE, 8'h5D,
            8'h01, 8'h00, 8'h00, 8'h80, 8'h01, sfr_pkg::DELIM_BYTE,
            // escape left pending at the close
            sfr_pkg::DELIM_BYTE, 8'h41, sfr_pkg::ESC_BYTE, sfr_pkg::DELIM_BYTE
        };
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        hold_until_drained();

        frame_no = 0;
        long_no  = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (frame_no % 8 == 0)
                calm = ($urandom_range(0, 3) == 0);
            // long frames only while they still fit in the byte budget
            if (frame_no % 16 == 15 && bytes_sent + RAW_LIMIT + 3 < ITEM_TARGET)
            begin
                // one past the limit first, then exactly at it, further
                // past it and one short of it
                case (long_no % 4)
                    0:       send_long_frame(RAW_LIMIT + 1);
                    1:       send_long_frame(RAW_LIMIT);
                    2:       send_long_frame(RAW_LIMIT + 2);
                    default: send_long_frame(RAW_LIMIT - 1);
                endcase
                long_no++;
            end
            else
            begin
                kind = $urandom_range(0, 19);
                if (kind < 14)
                    send_command_frame($urandom_range(7, 11));
                else if (kind < 16)
                    send_command_frame($urandom_range(0, 6));
                else if (kind < 18)
                    send_dangling_frame();
                else
                    send_line_noise();
            end
            if (frame_no == 20 || $urandom_range(0, 11) == 0)
                hold_until_drained();
            frame_no++;
        end

        // let every report come out, then give stray ones time to show up
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d bytes driven (%0d of them line noise), %0d frames",
                 bytes_sent, noise_bytes, frame_no);
        $display("summary: reports ok %0d, too short %0d, dangling escape %0d, overflow %0d",
                 status_tally[sfr_pkg::ST_OK], status_tally[sfr_pkg::ST_SHORT],
                 status_tally[sfr_pkg::ST_ESCAPE], status_tally[sfr_pkg::ST_OVERFLOW]);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
